// ===== rtl/vbs_pkg.sv =====
package vbs_pkg;

  // default sizing, handed down through the top level parameters
  localparam int unsigned PALETTE_DEPTH_DEF = 128;
  localparam int unsigned FRAC_BITS_DEF     = 16;

  // weight is unsigned Q0.16, so the translation product always drops 16 bits
  localparam int unsigned WEIGHT_BITS = 16;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned NUM_ROWS  = 4;      // three rotation rows, then translation
  localparam int unsigned ROW_W     = NUM_AXES * COORD_W;

  localparam logic [7:0] UNUSED_BONE = 8'hFF;

  // result FIFO; sized to cover the pipeline so a free-running sink sees full rate
  localparam int unsigned OUT_FIFO_DEPTH = 8;

  typedef enum logic {
    OP_PALETTE   = 1'b0,
    OP_INFLUENCE = 1'b1
  } op_t;

  // control that rides along with an influence through the pipe
  typedef struct packed {
    logic vld;
    logic hit;    // bone valid and in range, contributes to the sums
    logic last;
  } infl_ctl_t;

  // clamp a 64-bit sum to the signed 32-bit range
  function automatic logic [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic hi_ok;
    hi_ok = (v[SUM_W-1:COORD_W-1] == '0) || (v[SUM_W-1:COORD_W-1] == '1);
    if (hi_ok) begin
      sat32 = v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      sat32 = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/vbs_ram.sv =====
module vbs_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read, read returns the old word on a write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/vertex_blend_skinning_unit.sv =====
// Linear blend skinning unit.
// Input stream (in_*): one transfer per item. in_tuser selects the kind:
//   palette write - stores one row (rotation row 0..2 or translation row 3)
//                   of a bone into the palette;
//   influence     - adds A*M + weight*T to the position sums and B*M to the
//                   normal sums for the addressed bone. in_tlast closes the
//                   vertex and emits one result, then clears the sums.
// Bone 255, bones at or above cfg bone_limit, or beyond the palette add
// nothing; in_tlast on such an influence still emits.
// Result stream (out_*): skinned position and normal, Q16.16, clamped to 32 bits.
// Config: cfg_we loads bone_limit; write only while the unit is idle.
// Throughput: one item per cycle while in_tready is high, kinds mixed freely.
// The palette sits in four row RAMs, so all rows of a bone come out in one read.
// Pipeline: a closing influence reads the RAM on its transfer edge, then
// passes multiply, column add, accumulate and clamp into the FIFO.
// Reset (rst_n low, synchronous): sums, bone_limit and the FIFO clear; the
// palette holds garbage until written. No clearing pass.
// Stall: results queue in an 8-entry FIFO; in_tready drops once every slot is
// spoken for by queued or in-flight results, so nothing is dropped.
module vertex_blend_skinning_unit #(
  parameter int unsigned PALETTE_DEPTH = vbs_pkg::PALETTE_DEPTH_DEF,
  parameter int unsigned FRAC_BITS     = vbs_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // [7:0] bone, [9:8] row, [41:10] a_x, [73:42] a_y, [105:74] a_z,
  // [137:106] b_x, [169:138] b_y, [201:170] b_z, [217:202] weight, rest zero
  input  logic [223:0] in_tdata,
  input  logic         in_tuser,   // operation
  input  logic         in_tlast,   // last
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z,
  // [127:96] normal_x, [159:128] normal_y, [191:160] normal_z
  output logic [191:0] out_tdata,
  // config
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata   // bone_limit
);

  localparam int unsigned AW     = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned CW     = vbs_pkg::COORD_W;
  localparam int unsigned SW     = vbs_pkg::SUM_W;
  localparam int unsigned NAX    = vbs_pkg::NUM_AXES;
  localparam int unsigned NROW   = vbs_pkg::NUM_ROWS;
  localparam int unsigned RW     = vbs_pkg::ROW_W;
  localparam int unsigned WW     = vbs_pkg::WEIGHT_BITS;
  localparam int unsigned PWW    = WW + 1 + CW;           // weight * translation
  localparam int unsigned FDEPTH = vbs_pkg::OUT_FIFO_DEPTH;
  localparam int unsigned FAW    = $clog2(FDEPTH);
  localparam int unsigned OW     = 2 * NAX * CW;

  // ---------------------------------------------------------------- unpack
  logic [7:0]     bone;
  logic [1:0]     row;
  logic [CW-1:0]  a_in [NAX];
  logic [CW-1:0]  b_in [NAX];
  logic [WW-1:0]  weight;

  assign bone   = in_tdata[7:0];
  assign row    = in_tdata[9:8];
  assign weight = in_tdata[217:202];
  always_comb begin
    for (int c = 0; c < NAX; c++) begin
      a_in[c] = in_tdata[10 + CW*c +: CW];
      b_in[c] = in_tdata[106 + CW*c +: CW];
    end
  end

  // ---------------------------------------------------------------- config
  logic [7:0] bone_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bone_limit_r <= '0;
    end else if (cfg_we) begin
      bone_limit_r <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------- accept
  logic in_fire, is_infl, in_range, pal_wr;
  vbs_pkg::infl_ctl_t s1_nxt;

  assign in_fire  = in_tvalid && in_tready;
  assign is_infl  = (in_tuser == vbs_pkg::OP_INFLUENCE);
  assign in_range = ({24'd0, bone} < 32'(PALETTE_DEPTH));
  assign pal_wr   = in_fire && !is_infl && in_range;

  always_comb begin
    s1_nxt.vld  = in_fire && is_infl;
    s1_nxt.hit  = (bone != vbs_pkg::UNUSED_BONE) && (bone < bone_limit_r) && in_range;
    s1_nxt.last = in_tlast;
  end

  // ---------------------------------------------------------------- palette
  // one RAM per row, each word holds {z, y, x} of that row
  logic [RW-1:0] pal_rdata [NROW];
  logic [RW-1:0] pal_wdata;

  assign pal_wdata = {a_in[2], a_in[1], a_in[0]};

  for (genvar r = 0; r < NROW; r++) begin : g_row
    vbs_ram #(
      .WIDTH (RW),
      .DEPTH (PALETTE_DEPTH),
      .ADDR_W(AW)
    ) u_ram (
      .clk  (clk),
      .we   (pal_wr && (row == 2'(r))),
      .addr (bone[AW-1:0]),
      .wdata(pal_wdata),
      .rdata(pal_rdata[r])
    );
  end

  // ---------------------------------------------------------------- stage 1
  // operands wait here while the RAM read completes
  vbs_pkg::infl_ctl_t s1_r;
  logic [CW-1:0]      s1_a_r [NAX];
  logic [CW-1:0]      s1_b_r [NAX];
  logic [WW-1:0]      s1_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else begin
      s1_r <= s1_nxt;
    end
    s1_a_r <= a_in;
    s1_b_r <= b_in;
    s1_w_r <= weight;
  end

  // ---------------------------------------------------------------- stage 2: multiply
  vbs_pkg::infl_ctl_t    s2_r;
  logic signed [SW-1:0]  pa_r [NAX][NAX];   // [row][col]
  logic signed [SW-1:0]  pb_r [NAX][NAX];
  logic signed [PWW-1:0] pw_r [NAX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= '0;
    end else begin
      s2_r <= s1_r;
    end
    for (int r = 0; r < NAX; r++) begin
      for (int c = 0; c < NAX; c++) begin
        pa_r[r][c] <= $signed(s1_a_r[r]) * $signed(pal_rdata[r][CW*c +: CW]);
        pb_r[r][c] <= $signed(s1_b_r[r]) * $signed(pal_rdata[r][CW*c +: CW]);
      end
    end
    for (int c = 0; c < NAX; c++) begin
      pw_r[c] <= $signed({1'b0, s1_w_r}) * $signed(pal_rdata[NROW-1][CW*c +: CW]);
    end
  end

  // ---------------------------------------------------------------- stage 3: column sums
  vbs_pkg::infl_ctl_t   s3_r;
  logic signed [SW-1:0] colp_nxt [NAX];
  logic signed [SW-1:0] coln_nxt [NAX];
  logic signed [SW-1:0] colp_r   [NAX];
  logic signed [SW-1:0] coln_r   [NAX];

  always_comb begin
    logic signed [SW-1:0] wext;
    for (int c = 0; c < NAX; c++) begin
      wext = {{(SW-PWW){pw_r[c][PWW-1]}}, pw_r[c]};
      colp_nxt[c] = (pa_r[0][c] >>> FRAC_BITS) + (pa_r[1][c] >>> FRAC_BITS)
                  + (pa_r[2][c] >>> FRAC_BITS) + (wext >>> WW);
      coln_nxt[c] = (pb_r[0][c] >>> FRAC_BITS) + (pb_r[1][c] >>> FRAC_BITS)
                  + (pb_r[2][c] >>> FRAC_BITS);
      if (!s2_r.hit) begin
        colp_nxt[c] = '0;
        coln_nxt[c] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r <= '0;
    end else begin
      s3_r <= s2_r;
    end
    colp_r <= colp_nxt;
    coln_r <= coln_nxt;
  end

  // ---------------------------------------------------------------- stage 4: accumulate
  // the only loop-carried path: sum + column, one add per axis
  logic signed [SW-1:0] psum_r   [NAX];
  logic signed [SW-1:0] nsum_r   [NAX];
  logic signed [SW-1:0] ptot     [NAX];
  logic signed [SW-1:0] ntot     [NAX];
  logic                 fin_v_r;
  logic signed [SW-1:0] fin_p_r  [NAX];
  logic signed [SW-1:0] fin_n_r  [NAX];

  always_comb begin
    for (int c = 0; c < NAX; c++) begin
      ptot[c] = psum_r[c] + colp_r[c];
      ntot[c] = nsum_r[c] + coln_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NAX; c++) begin
        psum_r[c] <= '0;
        nsum_r[c] <= '0;
      end
      fin_v_r <= 1'b0;
    end else begin
      fin_v_r <= s3_r.vld && s3_r.last;
      if (s3_r.vld) begin
        for (int c = 0; c < NAX; c++) begin
          psum_r[c] <= s3_r.last ? '0 : ptot[c];
          nsum_r[c] <= s3_r.last ? '0 : ntot[c];
        end
      end
    end
    fin_p_r <= ptot;
    fin_n_r <= ntot;
  end

  // ---------------------------------------------------------------- result FIFO
  logic [OW-1:0]  fifo_mem [FDEPTH];
  logic [OW-1:0]  fifo_wdata;
  logic [FAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FAW:0]   fill_r, fill_nxt;
  logic [FAW:0]   credit_r, credit_nxt;   // queued plus in-flight results
  logic           out_fire, rsv;

  always_comb begin
    for (int c = 0; c < NAX; c++) begin
      fifo_wdata[CW*c +: CW]       = vbs_pkg::sat32(fin_p_r[c]);
      fifo_wdata[CW*(NAX+c) +: CW] = vbs_pkg::sat32(fin_n_r[c]);
    end
  end

  assign out_fire   = out_tvalid && out_tready;
  assign rsv        = in_fire && is_infl && in_tlast;
  assign in_tready  = (credit_r < (FAW+1)'(FDEPTH));
  assign out_tvalid = (fill_r != '0);
  assign out_tdata  = fifo_mem[rd_ptr_r];

  always_comb begin
    fill_nxt   = fill_r + (FAW+1)'(fin_v_r) - (FAW+1)'(out_fire);
    credit_nxt = credit_r + (FAW+1)'(rsv) - (FAW+1)'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      credit_r <= '0;
    end else begin
      if (fin_v_r) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fill_r   <= fill_nxt;
      credit_r <= credit_nxt;
    end
    if (fin_v_r) begin
      fifo_mem[wr_ptr_r] <= fifo_wdata;
    end
  end

  // ---------------------------------------------------------------- checks
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= (FAW+1)'(FDEPTH))
    else $error("result credits exceed FIFO depth");

  a_fill_le_credit: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= credit_r)
    else $error("FIFO holds more results than were reserved");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fin_v_r |-> (fill_r < (FAW+1)'(FDEPTH)))
    else $error("result written into a full FIFO");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_r.vld && s3_r.last) |=> (psum_r[0] == '0) && (nsum_r[0] == '0))
    else $error("sums not cleared after closing influence");

endmodule
